/* rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int unsigned ROWS_DEF    = 25;
  localparam int unsigned COLS_DEF    = 80;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [7:0] color_attr;
    logic [4:0] read_line;
    logic [6:0] read_column;
  } req_t;

  typedef struct packed {
    logic [4:0] cursor_line;
    logic [6:0] cursor_column;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } rsp_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] char_code;
    logic [7:0] color_attr;
    logic [4:0] line;
    logic [6:0] column;
  } cmd_t;

endpackage

/* rtl/tcw_front.sv */
// Request intake and command classification of the text console writer.
module tcw_front #(
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = tcw_pkg::COLS_DEF
) (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tcw_pkg::req_t in_req_i,
  input  logic          init_busy_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output tcw_pkg::cmd_t cmd_o
);

  logic line_ok;
  logic col_ok;

  assign line_ok = {1'b0, in_req_i.read_line} < 6'(ROWS);
  assign col_ok  = {1'b0, in_req_i.read_column} < 8'(COLS);

  assign in_ready_o = !queue_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.char_code  = in_req_i.char_code;
    cmd_o.color_attr = in_req_i.color_attr;
    cmd_o.line       = in_req_i.read_line;
    cmd_o.column     = in_req_i.read_column;
    unique case (in_req_i.mode)
      tcw_pkg::MODE_PUT: begin
        cmd_o.kind = (in_req_i.char_code == tcw_pkg::NEWLINE_CHAR) ?
                     tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT;
      end
      tcw_pkg::MODE_CLEAR: begin
        cmd_o.kind = tcw_pkg::CMD_CLEAR;
      end
      tcw_pkg::MODE_READ: begin
        cmd_o.kind = (line_ok && col_ok) ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
      end
      default: begin
        cmd_o.kind = tcw_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

/* rtl/tcw_queue.sv */
// Short command queue between front and back of the text console writer.
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          valid_o
);

  localparam int unsigned Depth = tcw_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tcw_pkg::cmd_t  slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/tcw_back.sv */
// Command execution, screen memory and cursor of the text console writer.
module tcw_back #(
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = tcw_pkg::COLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          cmd_valid_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          init_busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcw_pkg::rsp_t out_rsp_o
);

  localparam int unsigned RW       = $clog2(ROWS);
  localparam int unsigned CW       = $clog2(COLS);
  localparam int unsigned AW       = RW + CW;
  localparam int unsigned MemDepth = ROWS * (2 ** CW);

  localparam logic [RW-1:0] RowLast = RW'(ROWS - 1);
  localparam logic [CW-1:0] ColLast = CW'(COLS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;

  logic [15:0]   mem_q [MemDepth];
  logic [15:0]   rd_data_q;

  logic [2:0]    state_q, state_d;
  logic [RW-1:0] line_q, line_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] sr_q, sr_d;
  logic [CW-1:0] sc_q, sc_d;
  logic          copy_q, copy_d;
  logic          init_q, init_d;
  logic          pend_q;
  logic          pend_blank_q;
  logic [AW-1:0] pend_addr_q;
  logic [7:0]    blank_attr_q;
  logic          out_valid_q;
  tcw_pkg::rsp_t out_q;

  logic          cmd_pop;
  logic          put_we;
  logic          read_issue;
  logic          out_load;
  tcw_pkg::rsp_t load_rsp;
  logic          copy_row;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [7:0]    fill_attr;

  assign copy_row  = copy_q && (sr_q != RowLast);
  assign fill_attr = init_q ? tcw_pkg::RESET_ATTR : blank_attr_q;

  always_comb begin
    state_d    = state_q;
    line_d     = line_q;
    col_d      = col_q;
    sr_d       = sr_q;
    sc_d       = sc_q;
    copy_d     = copy_q;
    init_d     = init_q;
    cmd_pop    = 1'b0;
    put_we     = 1'b0;
    read_issue = 1'b0;
    out_load   = 1'b0;
    load_rsp   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || out_ready_i)) begin
          cmd_pop = 1'b1;
          unique case (cmd_i.kind)
            tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
              put_we = cmd_i.kind == tcw_pkg::CMD_PUT;
              if (cmd_i.kind == tcw_pkg::CMD_NEWLINE || col_q == ColLast) begin
                col_d = '0;
                if (line_q == RowLast) begin
                  state_d = ST_SWEEP;
                  copy_d  = 1'b1;
                  sr_d    = '0;
                  sc_d    = '0;
                end else begin
                  line_d   = line_q + RW'(1);
                  out_load = 1'b1;
                end
              end else begin
                col_d    = col_q + CW'(1);
                out_load = 1'b1;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              line_d  = '0;
              col_d   = '0;
              state_d = ST_SWEEP;
              copy_d  = 1'b0;
              sr_d    = '0;
              sc_d    = '0;
            end
            tcw_pkg::CMD_READ: begin
              read_issue = 1'b1;
              state_d    = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load           = 1'b1;
        load_rsp.cell_char = rd_data_q[15:8];
        load_rsp.cell_attr = rd_data_q[7:0];
        state_d            = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sc_q == ColLast) begin
          sc_d = '0;
          if (sr_q == RowLast) begin
            state_d = ST_DRAIN;
          end else begin
            sr_d = sr_q + RW'(1);
          end
        end else begin
          sc_d = sc_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (init_q) begin
          init_d = 1'b0;
        end else begin
          out_load          = 1'b1;
          load_rsp.scrolled = copy_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    load_rsp.cursor_line   = 5'(line_d);
    load_rsp.cursor_column = 7'(col_d);
  end

  assign mem_we = pend_q || put_we;
  assign mem_wa = pend_q ? pend_addr_q : {line_q, col_q};
  assign mem_wd = pend_q ? (pend_blank_q ? {tcw_pkg::BLANK_CHAR, fill_attr} : rd_data_q)
                         : {cmd_i.char_code, cmd_i.color_attr};
  assign mem_re = read_issue || (state_q == ST_SWEEP && copy_row);
  assign mem_ra = read_issue ? {cmd_i.line[RW-1:0], cmd_i.column[CW-1:0]}
                             : {sr_q + RW'(1), sc_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= {sr_q, sc_q};
    pend_blank_q <= !copy_row;
    if (out_load) begin
      out_q <= load_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      line_q       <= '0;
      col_q        <= '0;
      sr_q         <= '0;
      sc_q         <= '0;
      copy_q       <= 1'b0;
      init_q       <= 1'b1;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      blank_attr_q <= tcw_pkg::RESET_ATTR;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      col_q       <= col_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
      copy_q      <= copy_d;
      init_q      <= init_d;
      pend_q      <= state_q == ST_SWEEP;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (cfg_we_i) begin
        blank_attr_q <= cfg_wdata_i;
      end
    end
  end

  assign cmd_pop_o   = cmd_pop;
  assign init_busy_o = init_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q <= RowLast) && (col_q <= ColLast))
    else $error("cursor outside screen");

  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (!out_valid_q || out_ready_i))
    else $error("request taken with result register occupied");

  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !cmd_pop)
    else $error("request taken during initial screen fill");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scrolled) |->
      (out_q.cursor_line == 5'(ROWS - 1)) && (out_q.cursor_column == '0))
    else $error("scroll result with cursor off the bottom line start");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !put_we)
    else $error("sweep write collides with character write");
`endif

endmodule

/* rtl/text_console_writer.sv */
// Top level of the text console writer.
// Text console engine holding a ROWS x COLS screen of {character, attribute} cells in one
// on-chip memory plus a cursor. Each request gives exactly one result with the cursor after
// the request. A character put or newline that stays on the screen is done by the execution
// unit directly; a read goes through the registered memory read. A clear, or a put or
// newline that leaves the last line and scrolls, walks the whole screen once through the
// memory's single read and single write port. After reset the screen is filled with blanks
// by the same walk, during which in_ready_o stays low; blank_attr writes are taken at any
// time. A two-entry request queue lets intake continue while a long request runs.
module text_console_writer #(
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = tcw_pkg::COLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tcw_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcw_pkg::rsp_t out_rsp_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  logic          init_busy;
  logic          queue_full;
  logic          push;
  tcw_pkg::cmd_t front_cmd;
  logic          pop;
  tcw_pkg::cmd_t queue_cmd;
  logic          queue_valid;

  tcw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .init_busy_i (init_busy),
    .queue_full_i(queue_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (queue_full),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .valid_o(queue_valid)
  );

  tcw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (pop),
    .init_busy_o(init_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
